// File: design/tcw_pkg.sv
// Shared types and constants for the text console writer.
// No dependencies; imported by tcw_cursor and the top level.
package tcw_pkg;

  typedef enum logic [1:0] {
    ACT_PUT  = 2'd0,
    ACT_END  = 2'd1,
    ACT_READ = 2'd2,
    ACT_NOP  = 2'd3
  } tcw_action_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COPY,
    ST_LAST,
    ST_FILL,
    ST_FINISH
  } tcw_state_e;

  typedef struct packed {
    logic adv;
    logic newline;
    logic cret;
  } tcw_cur_cmd_t;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_RETURN  = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] ATTR_RESET = 8'h0F;

endpackage

// File: design/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; read data holds while no read is issued.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/tcw_cursor.sv
// Cursor tracker: linear index plus row and column counters.
// Depends on tcw_pkg for the command struct; flags a wrap that needs a scroll.
module tcw_cursor #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  tcw_pkg::tcw_cur_cmd_t                 cmd_i,
  output logic                                  wrap_o,
  output logic [$clog2(COLUMNS*ROWS)-1:0]       lin_o
);

  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CLW   = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);

  logic [AW-1:0]  lin_q, lin_d, line_start;
  logic [CLW-1:0] col_q, col_d;
  logic [RW-1:0]  row_q, row_d;
  logic           last_col, last_row;

  assign last_col   = (col_q == CLW'(COLUMNS - 1));
  assign last_row   = (row_q == RW'(ROWS - 1));
  assign line_start = lin_q - AW'(col_q);

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    lin_d  = lin_q;
    wrap_o = 1'b0;
    if (cmd_i.adv) begin
      if (last_col) begin
        col_d = '0;
        if (last_row) begin
          wrap_o = 1'b1;
          lin_d  = AW'(CELLS - COLUMNS);
        end else begin
          row_d = row_q + RW'(1);
          lin_d = lin_q + AW'(1);
        end
      end else begin
        col_d = col_q + CLW'(1);
        lin_d = lin_q + AW'(1);
      end
    end else if (cmd_i.newline) begin
      col_d = '0;
      if (last_row) begin
        wrap_o = 1'b1;
        lin_d  = line_start;
      end else begin
        row_d = row_q + RW'(1);
        lin_d = line_start + AW'(COLUMNS);
      end
    end else if (cmd_i.cret) begin
      col_d = '0;
      lin_d = line_start;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_q <= '0;
      col_q <= '0;
      row_q <= '0;
    end else begin
      lin_q <= lin_d;
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign lin_o = lin_q;

endmodule

// File: design/text_console_writer.sv
// Top level of the text console writer: request FSM, frame buffer sweeps,
// result register. Depends on tcw_pkg, tcw_ram and tcw_cursor.
//
//   channel  | handshake              | payload
//   ---------+------------------------+--------------------------------------------
//   in       | in_valid_i / in_stall_o| action_i, char_code_i, read_address_i
//   out      | out_valid_o/out_stall_i| cursor_position_o, cursor_published_o,
//            |                        | cell_char_o, cell_attr_o
//   cfg      | cfg_we_i               | cfg_wdata_i (text attribute)
//
// A request is accepted in idle; the result register loads in the finish state.
// A put that scrolls adds a copy sweep, moving each row but the first one row up,
// and a fill sweep that blanks the last row, through the single frame-buffer RAM
// port pair. After reset the frame buffer is cleared to zero; no request is taken
// meanwhile. A stalled result holds the block in its finish state.
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  char_code_i,
  input  logic [10:0] read_address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [10:0] cursor_position_o,
  output logic        cursor_published_o,
  output logic [7:0]  cell_char_o,
  output logic [7:0]  cell_attr_o
);

  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  tcw_state_e   state_q, state_d;
  tcw_action_e  act_q, act_d, in_act;
  tcw_cur_cmd_t cur_cmd;
  logic         wrap;
  logic [AW-1:0] cur_lin;

  logic [7:0]    attr_q;
  logic [AW-1:0] cnt_q, cnt_d, wa_q, wa_d;
  logic          pend_q, pend_d;
  logic          rd_ok_q, rd_ok_d;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0]   ram_wdata, ram_rdata;

  logic          accept, out_free, out_load;
  logic          out_valid_q;
  logic [10:0]   res_cursor_q;
  logic          res_pub_q;
  logic [7:0]    res_char_q, res_attr_q;

  assign in_act   = tcw_action_e'(action_i);
  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  tcw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cur_cmd),
    .wrap_o (wrap),
    .lin_o  (cur_lin)
  );

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_fb (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (cnt_q == AW'(CELLS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_d = wrap ? ST_COPY : ST_FINISH;
      end
      ST_COPY: begin
        if (cnt_q == AW'(CELLS - 1)) state_d = ST_LAST;
      end
      ST_LAST: state_d = ST_FILL;
      ST_FILL: begin
        if (cnt_q == AW'(CELLS - 1)) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    cur_cmd   = '0;
    ram_we    = 1'b0;
    ram_waddr = cnt_q;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = cnt_q;
    cnt_d     = cnt_q;
    wa_d      = wa_q;
    pend_d    = pend_q;
    act_d     = act_q;
    rd_ok_d   = rd_ok_q;
    out_load  = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
        cnt_d  = cnt_q + AW'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          act_d   = in_act;
          rd_ok_d = (32'(read_address_i) < CELLS);
          cnt_d   = AW'(COLUMNS);
          pend_d  = 1'b0;
          if (in_act == ACT_PUT) begin
            if (char_code_i == CH_NEWLINE) begin
              cur_cmd.newline = 1'b1;
            end else if (char_code_i == CH_RETURN) begin
              cur_cmd.cret = 1'b1;
            end else begin
              cur_cmd.adv = 1'b1;
              ram_we      = 1'b1;
              ram_waddr   = cur_lin;
              ram_wdata   = {attr_q, char_code_i};
            end
          end
          if (in_act == ACT_READ) begin
            ram_re    = 1'b1;
            ram_raddr = AW'(read_address_i);
          end
        end
      end
      ST_COPY: begin
        // read one row ahead, write the previous read one row up
        ram_re    = 1'b1;
        ram_we    = pend_q;
        ram_waddr = wa_q;
        ram_wdata = ram_rdata;
        pend_d    = 1'b1;
        wa_d      = cnt_q - AW'(COLUMNS);
        if (cnt_q != AW'(CELLS - 1)) cnt_d = cnt_q + AW'(1);
      end
      ST_LAST: begin
        ram_we    = 1'b1;
        ram_waddr = wa_q;
        ram_wdata = ram_rdata;
        cnt_d     = AW'(CELLS - COLUMNS);
      end
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = {attr_q, CH_SPACE};
        cnt_d     = cnt_q + AW'(1);
      end
      ST_FINISH: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      wa_q        <= '0;
      pend_q      <= 1'b0;
      act_q       <= ACT_NOP;
      rd_ok_q     <= 1'b0;
      attr_q      <= ATTR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      wa_q    <= wa_d;
      pend_q  <= pend_d;
      act_q   <= act_d;
      rd_ok_q <= rd_ok_d;
      if (cfg_we_i) attr_q <= cfg_wdata_i;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_cursor_q <= 11'(cur_lin);
      res_pub_q    <= (act_q == ACT_END);
      if (act_q == ACT_READ && rd_ok_q) begin
        res_char_q <= ram_rdata[7:0];
        res_attr_q <= ram_rdata[15:8];
      end else begin
        res_char_q <= '0;
        res_attr_q <= '0;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign cursor_position_o  = res_cursor_q;
  assign cursor_published_o = res_pub_q;
  assign cell_char_o        = res_char_q;
  assign cell_attr_o        = res_attr_q;

  a_wrap_scrolls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && wrap |=> state_q == ST_COPY)
    else $error("wrap did not start a scroll");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cur_lin) < CELLS)
    else $error("cursor outside frame buffer");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FINISH))
    else $error("result loaded outside finish state");

  a_idle_write_is_put: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we && state_q == ST_IDLE |-> accept && in_act == ACT_PUT)
    else $error("unexpected frame buffer write");

endmodule
